/* design/dpe_pkg.sv */
// ----------------------------------------------------------------------------
// dpe_pkg
// Shared types, command codes and helpers for the DVI position engine.
// ----------------------------------------------------------------------------
`default_nettype none

package dpe_pkg;

    // Field widths
    localparam int unsigned OP_W     = 5;
    localparam int unsigned CODE_W   = 16;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned NEST_W   = 6;
    localparam int unsigned FAULT_W  = 3;

    // Command codes
    localparam logic [OP_W-1:0] OP_SETCHAR = 5'd0;
    localparam logic [OP_W-1:0] OP_PUTCHAR = 5'd1;
    localparam logic [OP_W-1:0] OP_SETRULE = 5'd2;
    localparam logic [OP_W-1:0] OP_PUTRULE = 5'd3;
    localparam logic [OP_W-1:0] OP_PUSH    = 5'd4;
    localparam logic [OP_W-1:0] OP_POP     = 5'd5;
    localparam logic [OP_W-1:0] OP_RIGHT   = 5'd6;
    localparam logic [OP_W-1:0] OP_WSET    = 5'd7;
    localparam logic [OP_W-1:0] OP_W0      = 5'd8;
    localparam logic [OP_W-1:0] OP_XSET    = 5'd9;
    localparam logic [OP_W-1:0] OP_X0      = 5'd10;
    localparam logic [OP_W-1:0] OP_DOWN    = 5'd11;
    localparam logic [OP_W-1:0] OP_YSET    = 5'd12;
    localparam logic [OP_W-1:0] OP_Y0      = 5'd13;
    localparam logic [OP_W-1:0] OP_ZSET    = 5'd14;
    localparam logic [OP_W-1:0] OP_Z0      = 5'd15;
    localparam logic [OP_W-1:0] OP_BOP     = 5'd16;
    localparam logic [OP_W-1:0] OP_EOP     = 5'd17;
    localparam logic [OP_W-1:0] OP_SPECIAL = 5'd18;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHAR    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RULE    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SPECIAL = 2'd3;

    // Fault codes
    localparam logic [FAULT_W-1:0] FAULT_OK        = 3'd0;
    localparam logic [FAULT_W-1:0] FAULT_OVERFLOW  = 3'd1;
    localparam logic [FAULT_W-1:0] FAULT_UNDERFLOW = 3'd2;
    localparam logic [FAULT_W-1:0] FAULT_NESTED    = 3'd3;
    localparam logic [FAULT_W-1:0] FAULT_OPEN_EOP  = 3'd4;

    // One command word
    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic signed [31:0] amount;
        logic [CODE_W-1:0] char_code;
        logic signed [31:0] char_advance;
        logic signed [31:0] rule_height;
    } cmd_t;

    // One result word
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [CODE_W-1:0]  glyph;
        logic signed [31:0] box_width;
        logic signed [31:0] box_height;
        logic [NEST_W-1:0]  nesting;
        logic [FAULT_W-1:0] fault;
    } res_t;

    // Position and spacing registers, saved as one stack level
    typedef struct packed {
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
        logic [31:0] w;
        logic [31:0] v;
        logic [31:0] h;
    } frame_t;

    // Stack operation requested by the executed command
    typedef struct packed {
        logic push;
        logic pop;
    } stack_ctrl_t;

    // Strictly positive 32-bit value
    function automatic logic is_positive(input logic signed [31:0] val);
        return val > 32'sd0;
    endfunction

endpackage

`default_nettype wire

/* design/dvi_position_engine.sv */
// Pipeline: an accepted command is loaded into the input register; it moves
//   on into the result register when that register is empty or not stalled.
// Throughput: one command per cycle while res_stall is low; the stack's top level sits in
//   registers and the memory read of the level below is prefetched.
// Reset: asynchronous, active low; clears h, v, w, x, y, z, stack depth,
//   page flag and valid bits. Stack memory contents are not cleared.
// ----------------------------------------------------------------------------
// dvi_position_engine
// Executes decoded DVI page commands and reports drawing positions.
// ----------------------------------------------------------------------------
`default_nettype none

module dvi_position_engine
    import dpe_pkg::*;
#(
    parameter int unsigned MAX_LEVELS = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cmd_valid,
    output logic        cmd_stall,
    input  wire cmd_t   cmd,
    output logic        res_valid,
    input  wire logic   res_stall,
    output res_t        res
);

    localparam int unsigned SPW = $clog2(MAX_LEVELS + 1);
    localparam int unsigned AW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

    // Input register
    logic        in_vld_reg;
    cmd_t        in_cmd_reg;

    // Architectural state
    frame_t          frame_reg;
    frame_t          top_reg;
    logic [SPW-1:0]  sp_reg;
    logic            in_page_reg;

    // Result register
    logic        out_vld_reg;
    res_t        out_res_reg;

    // Execute outputs
    frame_t          frame_next;
    frame_t          top_next;
    logic [SPW-1:0]  sp_next;
    logic            in_page_next;
    stack_ctrl_t     ctrl;
    res_t            exec_res;

    // Stack memory ports
    frame_t          below;
    logic            wr_en;
    logic [AW-1:0]   wr_ptr;
    logic [AW-1:0]   rd_ptr;

    logic            advance;
    logic            accept;

    // Handshake
    assign advance   = in_vld_reg && (!out_vld_reg || !res_stall);
    assign cmd_stall = in_vld_reg && !advance;
    assign accept    = cmd_valid && !cmd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_cmd_reg <= cmd;
        end
    end

    // Command execution
    dpe_exec #(
        .MAX_LEVELS (MAX_LEVELS),
        .SPW        (SPW)
    ) u_exec (
        .cmd          (in_cmd_reg),
        .cur          (frame_reg),
        .sp           (sp_reg),
        .in_page      (in_page_reg),
        .top          (top_reg),
        .nxt          (frame_next),
        .sp_next      (sp_next),
        .in_page_next (in_page_next),
        .ctrl         (ctrl),
        .res          (exec_res)
    );

    // Push demotes the top level into memory; pop promotes the prefetched one
    assign wr_en  = advance && ctrl.push && (sp_reg != '0);
    assign wr_ptr = sp_reg[AW-1:0] - AW'(1);
    assign rd_ptr = (advance ? sp_next[AW-1:0] : sp_reg[AW-1:0]) - AW'(2);

    always_comb
    begin
        top_next = top_reg;
        if (ctrl.push)
        begin
            top_next = frame_reg;
        end
        else if (ctrl.pop)
        begin
            top_next = below;
        end
    end

    dpe_stack #(
        .AW (AW)
    ) u_stack (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_ptr),
        .wr_data (top_reg),
        .rd_addr (rd_ptr),
        .rd_data (below)
    );

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg   <= '0;
            sp_reg      <= '0;
            in_page_reg <= 1'b0;
        end
        else if (advance)
        begin
            frame_reg   <= frame_next;
            sp_reg      <= sp_next;
            in_page_reg <= in_page_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            top_reg <= top_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= exec_res;
        end
    end

    assign res_valid = out_vld_reg;
    assign res       = out_res_reg;

`ifndef SYNTHESIS
    // depth never exceeds the stack size
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(MAX_LEVELS))
        else $error("stack depth beyond limit");

    // a successful push raises the depth by one
    a_push_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && ctrl.push) |=> (sp_reg == $past(sp_reg) + SPW'(1)))
        else $error("push did not raise depth");

    // a successful pop restores the saved top level
    a_pop_restore: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && ctrl.pop) |=> (frame_reg == $past(top_reg)))
        else $error("pop did not restore saved level");

    // nothing drawn carries no position or box
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.kind == KIND_NONE)) |->
            ((res.pos_x == 32'sd0) && (res.pos_y == 32'sd0) &&
             (res.glyph == '0) && (res.box_width == 32'sd0) &&
             (res.box_height == 32'sd0)))
        else $error("empty result carries data");
`endif

endmodule

`default_nettype wire

/* design/dpe_stack.sv */
// ----------------------------------------------------------------------------
// dpe_stack
// Storage for the stack levels below the top one. One write port, one
// registered read port; a write to the address being read is forwarded.
// ----------------------------------------------------------------------------
`default_nettype none

module dpe_stack
    import dpe_pkg::*;
#(
    parameter int unsigned AW = 5
) (
    input  wire logic               clk,
    input  wire logic               wr_en,
    input  wire logic [AW-1:0]      wr_addr,
    input  wire frame_t             wr_data,
    input  wire logic [AW-1:0]      rd_addr,
    output frame_t                  rd_data
);

    localparam int unsigned DEPTH = 1 << AW;

    frame_t mem_reg [0:DEPTH-1];
    frame_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read with write-first forwarding
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* design/dpe_exec.sv */
// ----------------------------------------------------------------------------
// dpe_exec
// Command execution: next register values, stack request and result word
// for one command, computed from the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module dpe_exec
    import dpe_pkg::*;
#(
    parameter int unsigned MAX_LEVELS = 32,
    parameter int unsigned SPW        = 6
) (
    input  wire cmd_t               cmd,
    input  wire frame_t             cur,
    input  wire logic [SPW-1:0]     sp,
    input  wire logic               in_page,
    input  wire frame_t             top,
    output frame_t                  nxt,
    output logic [SPW-1:0]          sp_next,
    output logic                    in_page_next,
    output stack_ctrl_t             ctrl,
    output res_t                    res
);

    logic [31:0] amt;
    logic [31:0] cur_y;
    logic        stack_full;
    logic        stack_empty;

    assign amt         = $unsigned(cmd.amount);
    assign cur_y       = 32'd0 - cur.v;
    assign stack_full  = (sp >= SPW'(MAX_LEVELS));
    assign stack_empty = (sp == '0);

    always_comb
    begin
        nxt          = cur;
        sp_next      = sp;
        in_page_next = in_page;
        ctrl         = '0;
        res          = '0;

        case (cmd.operation)
            OP_SETCHAR, OP_PUTCHAR:
            begin
                res.kind      = KIND_CHAR;
                res.pos_x     = $signed(cur.h);
                res.pos_y     = $signed(cur_y);
                res.glyph     = cmd.char_code;
                res.box_width = cmd.char_advance;
                if (cmd.operation == OP_SETCHAR)
                begin
                    nxt.h = cur.h + $unsigned(cmd.char_advance);
                end
            end
            OP_SETRULE, OP_PUTRULE:
            begin
                // rules with a non-positive side draw nothing
                if (is_positive(cmd.amount) && is_positive(cmd.rule_height))
                begin
                    res.kind       = KIND_RULE;
                    res.pos_x      = $signed(cur.h);
                    res.pos_y      = $signed(cur_y);
                    res.box_width  = cmd.amount;
                    res.box_height = cmd.rule_height;
                end
                if (cmd.operation == OP_SETRULE)
                begin
                    nxt.h = cur.h + amt;
                end
            end
            OP_PUSH:
            begin
                if (stack_full)
                begin
                    res.fault = FAULT_OVERFLOW;
                end
                else
                begin
                    ctrl.push = 1'b1;
                    sp_next   = sp + SPW'(1);
                end
            end
            OP_POP:
            begin
                if (stack_empty)
                begin
                    res.fault = FAULT_UNDERFLOW;
                end
                else
                begin
                    ctrl.pop = 1'b1;
                    sp_next  = sp - SPW'(1);
                    nxt      = top;
                end
            end
            OP_RIGHT: nxt.h = cur.h + amt;
            OP_WSET:
            begin
                nxt.w = amt;
                nxt.h = cur.h + amt;
            end
            OP_W0: nxt.h = cur.h + cur.w;
            OP_XSET:
            begin
                nxt.x = amt;
                nxt.h = cur.h + amt;
            end
            OP_X0: nxt.h = cur.h + cur.x;
            OP_DOWN: nxt.v = cur.v + amt;
            OP_YSET:
            begin
                nxt.y = amt;
                nxt.v = cur.v + amt;
            end
            OP_Y0: nxt.v = cur.v + cur.y;
            OP_ZSET:
            begin
                nxt.z = amt;
                nxt.v = cur.v + amt;
            end
            OP_Z0: nxt.v = cur.v + cur.z;
            OP_BOP:
            begin
                if (in_page)
                begin
                    res.fault = FAULT_NESTED;
                end
                nxt          = '0;
                sp_next      = '0;
                in_page_next = 1'b1;
            end
            OP_EOP:
            begin
                in_page_next = 1'b0;
                if (!stack_empty)
                begin
                    res.fault = FAULT_OPEN_EOP;
                end
            end
            OP_SPECIAL:
            begin
                res.kind  = KIND_SPECIAL;
                res.pos_x = $signed(cur.h);
                res.pos_y = $signed(cur_y);
            end
            default:
            begin
                // unused codes leave everything as it is
            end
        endcase

        res.nesting = NEST_W'(sp_next);
    end

endmodule

`default_nettype wire
